@@ sv/dda_pkg.sv @@
// Package: shared types, constants and the operation schedule of the double-double adder.
package dda_pkg;

	localparam int WORD_W = 64;
	localparam int SLOTS  = 8;
	localparam int NSTEPS = 14;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [$clog2(SLOTS)-1:0] slot_t;
	typedef logic [SLOTS-1:0][WORD_W-1:0] ctx_t;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	localparam word_t DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

	// one schedule step: up to two binary64 ops on context slots
	typedef struct packed {
		slot_t a0;
		slot_t b0;
		logic  sub0;
		slot_t d0;
		logic  use1;
		slot_t a1;
		slot_t b1;
		logic  sub1;
		slot_t d1;
	} step_t;

	// slots on entry: 0 ah, 1 al, 2 bh, 3 bl
	localparam step_t STEPS [NSTEPS] = '{
		'{3'd0, 3'd2, OP_ADD, 3'd4, 1'b1, 3'd1, 3'd3, OP_ADD, 3'd5},
		'{3'd4, 3'd0, OP_SUB, 3'd6, 1'b1, 3'd5, 3'd1, OP_SUB, 3'd7},
		'{3'd2, 3'd6, OP_SUB, 3'd2, 1'b1, 3'd3, 3'd7, OP_SUB, 3'd3},
		'{3'd4, 3'd6, OP_SUB, 3'd6, 1'b1, 3'd5, 3'd7, OP_SUB, 3'd7},
		'{3'd0, 3'd6, OP_SUB, 3'd0, 1'b1, 3'd1, 3'd7, OP_SUB, 3'd1},
		'{3'd0, 3'd2, OP_ADD, 3'd0, 1'b1, 3'd1, 3'd3, OP_ADD, 3'd1},
		'{3'd0, 3'd5, OP_ADD, 3'd0, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd4, 3'd0, OP_ADD, 3'd2, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd2, 3'd4, OP_SUB, 3'd3, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd0, 3'd3, OP_SUB, 3'd0, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd0, 3'd1, OP_ADD, 3'd0, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd2, 3'd0, OP_ADD, 3'd3, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd3, 3'd2, OP_SUB, 3'd4, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0},
		'{3'd0, 3'd4, OP_SUB, 3'd0, 1'b0, 3'd0, 3'd0, OP_ADD, 3'd0}
	};

	localparam slot_t OUT_HI = 3'd3;
	localparam slot_t OUT_LO = 3'd0;

endpackage

@@ sv/double_double_adder_top.sv @@
// Top level: pipelined double-double adder.
//
// Input channel: in_valid / in_stall with first_high, first_low, second_high,
// second_low, each a binary64 bit pattern. A transfer happens on a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with sum_high, sum_low. A transfer
// happens on a rising edge with out_valid high and out_stall low.
//
// Throughput: one item per cycle while the output is not stalled. The path is
// a chain of 14 dependent binary64 add steps, each a 3-stage adder.
//
// Reset (arst_n low) empties the pipeline; no result is shown until an item
// has passed through. When the receiver stalls a waiting result, the whole
// pipeline holds and in_stall is raised in the same cycle; nothing is lost
// or repeated. Idle slots move on freely while the output is not stalled.
module double_double_adder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  dda_pkg::word_t first_high,
	input  dda_pkg::word_t first_low,
	input  dda_pkg::word_t second_high,
	input  dda_pkg::word_t second_low,
	output logic           out_valid,
	input  logic           out_stall,
	output dda_pkg::word_t sum_high,
	output dda_pkg::word_t sum_low
);
	import dda_pkg::*;

	ctx_t ctx_c [NSTEPS+1];
	logic val_c [NSTEPS+1];
	logic en;

	assign ctx_c[0] = {{(4*WORD_W){1'b0}}, second_low, second_high, first_low, first_high};
	assign val_c[0] = in_valid;

	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		dda_step u_step (
			.clk(clk), .arst_n(arst_n), .en(en), .step(STEPS[i]),
			.valid_in(val_c[i]), .ctx_in(ctx_c[i]),
			.valid_out(val_c[i+1]), .ctx_out(ctx_c[i+1])
		);
	end

	assign in_stall  = val_c[NSTEPS] && out_stall;
	assign en        = !in_stall;
	assign out_valid = val_c[NSTEPS];
	assign sum_high  = ctx_c[NSTEPS][OUT_HI];
	assign sum_low   = ctx_c[NSTEPS][OUT_LO];

endmodule

@@ sv/dda_fp_add.sv @@
// Three-stage binary64 adder/subtractor, round to nearest even, x86-style NaN rules.
module dda_fp_add (
	input  logic           clk,
	input  logic           en,
	input  dda_pkg::word_t a,
	input  dda_pkg::word_t b,
	input  logic           sub,
	output dda_pkg::word_t res
);
	import dda_pkg::*;

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) n = 6'(55 - i);
		end
		return n;
	endfunction

	// stage 1: specials, swap, align
	word_t       b_eff, big, sml, spcv;
	logic        a_nan, b_nan, a_inf, b_inf, spc, swap;
	logic [10:0] eb1, es1, d;
	logic [55:0] mb, ms, al, ms_al;
	logic        st;

	logic        spc_s1, sign_s1, esub_s1;
	word_t       spcv_s1;
	logic [10:0] exp_s1;
	logic [55:0] mb_s1, ms_s1;

	always_comb begin
		b_eff = {b[63] ^ sub, b[62:0]};
		a_nan = (&a[62:52]) && (|a[51:0]);
		b_nan = (&b[62:52]) && (|b[51:0]);
		a_inf = (&a[62:52]) && !(|a[51:0]);
		b_inf = (&b[62:52]) && !(|b[51:0]);
		spc   = 1'b1;
		if (a_nan) spcv = a | 64'h0008_0000_0000_0000;
		else if (b_nan) spcv = b | 64'h0008_0000_0000_0000;
		else if (a_inf && b_inf && (a[63] != b_eff[63])) spcv = DEFAULT_NAN;
		else if (a_inf) spcv = a;
		else if (b_inf) spcv = b_eff;
		else begin
			spcv = '0;
			spc  = 1'b0;
		end
		swap = b_eff[62:0] > a[62:0];
		big  = swap ? b_eff : a;
		sml  = swap ? a : b_eff;
		eb1  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		es1  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
		mb   = {big[62:52] != 11'd0, big[51:0], 3'b000};
		ms   = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
		d    = eb1 - es1;
		if (d >= 11'd56) begin
			al = '0;
			st = |ms;
		end else begin
			al = ms >> d[5:0];
			st = |(ms & ~({56{1'b1}} << d[5:0]));
		end
		ms_al = {al[55:1], al[0] | st};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spc_s1  <= spc;
			spcv_s1 <= spcv;
			sign_s1 <= big[63];
			esub_s1 <= big[63] ^ sml[63];
			exp_s1  <= eb1;
			mb_s1   <= mb;
			ms_s1   <= ms_al;
		end
	end

	// stage 2: add and leading-zero count
	logic [56:0] sum;
	logic        spc_s2, sign_s2, esub_s2;
	word_t       spcv_s2;
	logic [10:0] exp_s2;
	logic [56:0] sum_s2;
	logic [5:0]  lz_s2;

	always_comb begin
		sum = esub_s1 ? ({1'b0, mb_s1} - {1'b0, ms_s1}) : ({1'b0, mb_s1} + {1'b0, ms_s1});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spc_s2  <= spc_s1;
			spcv_s2 <= spcv_s1;
			sign_s2 <= sign_s1;
			esub_s2 <= esub_s1;
			exp_s2  <= exp_s1;
			sum_s2  <= sum;
			lz_s2   <= lzc56(sum[55:0]);
		end
	end

	// stage 3: normalize and round
	logic [55:0] m;
	logic [11:0] e;
	logic [10:0] sh, ef;
	logic        rnd, sgn;
	word_t       r;

	always_comb begin
		if (sum_s2[56]) begin
			m  = {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			e  = {1'b0, exp_s2} + 12'd1;
			sh = '0;
		end else begin
			sh = ({5'd0, lz_s2} < (exp_s2 - 11'd1)) ? {5'd0, lz_s2} : (exp_s2 - 11'd1);
			m  = sum_s2[55:0] << sh;
			e  = {1'b0, exp_s2} - {1'b0, sh};
		end
		ef  = m[55] ? e[10:0] : 11'd0;
		rnd = m[2] & (m[1] | m[0] | m[3]);
		sgn = (sum_s2 == 57'd0 && esub_s2) ? 1'b0 : sign_s2;
		if (spc_s2) r = spcv_s2;
		else if (e == 12'd2047) r = {sgn, 11'h7FF, 52'd0};
		else r = {sgn, ({ef, m[54:3]} + {62'd0, rnd})};
	end

	always_ff @(posedge clk) begin
		if (en) res <= r;
	end

endmodule

@@ sv/dda_step.sv @@
// One schedule step: two binary64 adders over the context, with the context delayed alongside.
module dda_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  dda_pkg::step_t step,
	input  logic           valid_in,
	input  dda_pkg::ctx_t  ctx_in,
	output logic           valid_out,
	output dda_pkg::ctx_t  ctx_out
);
	import dda_pkg::*;

	word_t r0, r1;
	logic  v_s1, v_s2, v_s3;
	ctx_t  ctx_s1, ctx_s2, ctx_s3;

	dda_fp_add u_add0 (
		.clk(clk), .en(en),
		.a(ctx_in[step.a0]), .b(ctx_in[step.b0]), .sub(step.sub0), .res(r0)
	);

	dda_fp_add u_add1 (
		.clk(clk), .en(en),
		.a(ctx_in[step.a1]), .b(ctx_in[step.b1]), .sub(step.sub1), .res(r1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			ctx_s2 <= ctx_s1;
			ctx_s3 <= ctx_s2;
		end
	end

	always_comb begin
		ctx_out = ctx_s3;
		ctx_out[step.d0] = r0;
		if (step.use1) ctx_out[step.d1] = r1;
	end

	assign valid_out = v_s3;

endmodule

@@ sv/dda_checker.sv @@
// Checker for the double-double adder ports, bound to the top level.
module dda_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input dda_pkg::word_t sum_high,
	input dda_pkg::word_t sum_low
);
	import dda_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_high) && $stable(sum_low))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	a_nan_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (&sum_high[62:52]) && (|sum_high[51:0]) |->
		(&sum_low[62:52]) && (|sum_low[51:0]))
		else $error("NaN high word with non-NaN low word");

endmodule

bind double_double_adder_top dda_checker u_dda_checker (.*);
